### rtl/core/maf_pkg.sv
// Shared constants, state encoding and control types for the moving average filter.
package maf_pkg;

   localparam int DEF_MAX_WINDOW = 16;
   localparam int SAMPLE_W       = 16;
   localparam int CFG_W          = 5;
   localparam int DEF_WINDOW_LEN = 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic div_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

### rtl/core/maf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module maf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/maf_ctrl.sv
// Controller state machine that sequences update, division and result hand-off.
module maf_ctrl
   import maf_pkg::*;
#(
   parameter int SUM_W = 21
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam int CNT_W = $clog2(SUM_W);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_UPDATE;
         end
         ST_UPDATE: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (count_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (state_ff == ST_UPDATE) begin
         count_in = CNT_W'(SUM_W - 1);
      end else if (state_ff == ST_DIVIDE && count_ff != '0) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      cmd.accept   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.update   = (state_ff == ST_UPDATE);
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.load_out = (state_ff == ST_FINISH) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/maf_datapath.sv
// Datapath: sample ring, running sum, restoring divider and output register.
module maf_datapath
   import maf_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW) + 1,
   parameter int LEN_W      = $clog2(MAX_WINDOW + 1),
   parameter int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic [SAMPLE_W-1:0] req_tdata,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata
);

   localparam int RESET_LEN = (DEF_WINDOW_LEN > MAX_WINDOW) ? MAX_WINDOW : DEF_WINDOW_LEN;

   logic [LEN_W-1:0]           len_ff, len_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [LEN_W-1:0]           fill_ff, fill_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [LEN_W-1:0]           rem_ff, rem_in;
   logic [SUM_W-1:0]           quo_ff, quo_in;
   logic                       neg_ff, neg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;

   logic [SAMPLE_W-1:0]        ram_rd_data;
   logic signed [SAMPLE_W-1:0] old_sample;
   logic signed [SUM_W-1:0]    sum_upd;
   logic [LEN_W-1:0]           idx_inc;
   logic [LEN_W:0]             shifted;
   logic [SUM_W-1:0]           quo_signed;

   maf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW),
      .AW    (IDX_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (idx_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.accept),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // A slot beyond the fill count has not been written since the last clear.
   assign old_sample = (LEN_W'(idx_ff) < fill_ff) ? signed'(ram_rd_data) : '0;
   assign sum_upd    = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
   assign idx_inc    = LEN_W'(idx_ff) + 1'b1;
   assign shifted    = {rem_ff, quo_ff[SUM_W-1]};
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_comb begin
      len_in  = len_ff;
      idx_in  = idx_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            len_in = LEN_W'(1);
         end else if (32'(csr_wr_data) > MAX_WINDOW) begin
            len_in = LEN_W'(MAX_WINDOW);
         end else begin
            len_in = LEN_W'(csr_wr_data);
         end
         idx_in  = '0;
         fill_in = '0;
         sum_in  = '0;
      end else if (cmd.update) begin
         sum_in = sum_upd;
         idx_in = (idx_inc >= len_ff) ? '0 : IDX_W'(idx_inc);
         if (fill_ff != len_ff) fill_in = fill_ff + 1'b1;
         neg_in = sum_upd[SUM_W-1];
         quo_in = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (shifted >= {1'b0, len_ff}) begin
            rem_in = LEN_W'(shifted - {1'b0, len_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[LEN_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = quo_signed[SAMPLE_W-1:0];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_W'(RESET_LEN);
         idx_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) sample_ff <= signed'(req_tdata);
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

### rtl/core/moving_average_filter_core.sv
// Top level of the moving average filter: controller and datapath joined together.
//
// This block keeps a simple moving average over the last window_len signed
// 16-bit samples held in a ring RAM of MAX_WINDOW slots, and returns one mean
// per input transaction, truncated toward zero. Each transaction steps through
// accepting the sample and reading the oldest slot, updating the running sum
// and the ring, the one-bit-per-cycle restoring divider, and loading the
// output register once it is free. The next sample is accepted while a
// finished mean still waits in the output register. Writing the window
// length register clears the running sum, the write pointer and the fill
// count, so unwritten slots read as zero; a length of zero acts as one, and a
// length above MAX_WINDOW acts as MAX_WINDOW. No clearing pass is needed
// after reset, and the register must be written only while the block is idle.
module moving_average_filter_core
   import maf_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
   input  logic                clock,
   input  logic                reset,
   // Input samples.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // [15:0] sample
   // Averaged results.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,   // [15:0] mean
   // Window length register.
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data  // [4:0] window_len
);

   // The running sum needs enough headroom for MAX_WINDOW full-scale samples.
   localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW) + 1;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller only sequences with its state and step counter; all filter data lives in the datapath.
   maf_ctrl #(
      .SUM_W (SUM_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   maf_datapath #(
      .MAX_WINDOW (MAX_WINDOW),
      .SUM_W      (SUM_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
